>>> rtl/core/sap_pkg.sv
// Shared types and constants for the skyline atlas placer.
// No dependencies; imported by sap_ctrl, sap_datapath and the top level.
`default_nettype none
package sap_pkg;

  localparam int ATLAS_W = 256;
  localparam int ATLAS_H = 256;
  localparam int COL_W   = $clog2(ATLAS_W);
  localparam int SKY_W   = 9;
  localparam int DIM_W   = 9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic rd_issue;
    logic commit;
    logic wr_issue;
    logic fail;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic too_wide;
    logic cnt_end;
    logic fits;
  } ctrl_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/skyline_atlas_placer_unit.sv
// Skyline atlas placer top level: controller plus datapath.
// Depends on sap_pkg, sap_ctrl and sap_datapath.
//
// A rectangle is taken when start is high and busy is low; its placement
// appears on place_x, place_y and overflow for the single cycle in which
// done is high, and the receiver cannot hold it off. The skyline memory is
// read once and written once per covered column of a placed rectangle;
// one that is too wide fails in the setup state without any access, and
// one that is too tall fails after its column reads, with no writes.
// The skyline starts cleared after reset with no clearing pass.
`default_nettype none
module skyline_atlas_placer_unit import sap_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [DIM_W-1:0]   rect_width,
  input  wire logic [DIM_W-1:0]   rect_height,
  output logic                    done,
  output logic      [COL_W-1:0]   place_x,
  output logic      [SKY_W-1:0]   place_y,
  output logic                    overflow
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sap_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sap_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .place_x     (place_x),
    .place_y     (place_y),
    .overflow    (overflow)
  );

endmodule
`default_nettype wire

>>> rtl/core/sap_ctrl.sv
// Controller state machine for the skyline atlas placer.
// Depends on sap_pkg; drives sap_datapath through ctrl_cmd_t.
`default_nettype none
module sap_ctrl import sap_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire ctrl_sts_t  sts,
  output ctrl_cmd_t       cmd,
  output logic            busy,
  output logic            done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        if (sts.too_wide) begin
          cmd.fail   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.setup  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.cnt_end) begin
          state_next = S_CHECK;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts.fits) begin
          cmd.commit = 1'b1;
          state_next = S_WRITE;
        end else begin
          cmd.fail   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_WRITE: begin
        if (sts.cnt_end) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.wr_issue = 1'b1;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/sap_datapath.sv
// Datapath of the skyline atlas placer: skyline memory, cursor, column scan.
// Depends on sap_pkg; steered by sap_ctrl.
`default_nettype none
module sap_datapath import sap_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts,
  input  wire logic [DIM_W-1:0]   rect_width,
  input  wire logic [DIM_W-1:0]   rect_height,
  output logic      [COL_W-1:0]   place_x,
  output logic      [SKY_W-1:0]   place_y,
  output logic                    overflow
);

  localparam logic [DIM_W:0] ATLAS_W_V = (DIM_W+1)'(ATLAS_W);
  localparam logic [DIM_W:0] ATLAS_H_V = (DIM_W+1)'(ATLAS_H);

  logic [SKY_W-1:0] sky_mem [ATLAS_W];
  logic [ATLAS_W-1:0] valid;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [COL_W-1:0] x;
  logic [DIM_W-1:0] cursor;
  logic [DIM_W-1:0] cnt;
  logic [SKY_W-1:0] row;
  logic [SKY_W-1:0] rd_data;
  logic             rd_vld;
  logic             rd_pend;

  logic [COL_W-1:0] addr;
  logic [DIM_W:0]   cur_end;
  logic [DIM_W:0]   top_sum;
  logic [SKY_W-1:0] sky_new;
  logic [SKY_W-1:0] rd_eff;

  assign addr    = x + cnt[COL_W-1:0];
  assign cur_end = {1'b0, cursor} + {1'b0, w};
  assign top_sum = {1'b0, row} + {1'b0, h};
  assign sky_new = top_sum[SKY_W-1:0] + SKY_W'(1);
  assign rd_eff  = rd_vld ? rd_data : '0;

  assign sts.too_wide = {1'b0, w} > ATLAS_W_V;
  assign sts.cnt_end  = (cnt == w);
  assign sts.fits     = top_sum <= ATLAS_H_V;

  always_ff @(posedge clk) begin
    if (cmd.wr_issue) begin
      sky_mem[addr] <= sky_new;
    end
    if (cmd.rd_issue) begin
      rd_data <= sky_mem[addr];
      rd_vld  <= valid[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      cursor  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
      if (cmd.wr_issue) begin
        valid[addr] <= 1'b1;
      end
      if (cmd.finish) begin
        cursor <= DIM_W'({1'b0, x} + {1'b0, w} + (DIM_W+1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w <= rect_width;
      h <= rect_height;
    end
    if (cmd.setup) begin
      if ({1'b0, cursor} >= ATLAS_W_V || cur_end > ATLAS_W_V) begin
        x <= '0;
      end else begin
        x <= cursor[COL_W-1:0];
      end
      cnt <= '0;
      row <= '0;
    end else if (cmd.commit) begin
      cnt <= '0;
    end else if (cmd.rd_issue || cmd.wr_issue) begin
      cnt <= cnt + DIM_W'(1);
    end
    if (rd_pend && rd_eff > row) begin
      row <= rd_eff;
    end
    if (cmd.fail) begin
      place_x  <= '0;
      place_y  <= '0;
      overflow <= 1'b1;
    end else if (cmd.finish) begin
      place_x  <= x;
      place_y  <= row;
      overflow <= 1'b0;
    end
  end

endmodule
`default_nettype wire
